>>> src/eged_pkg.sv
// ----------------------------------------------------------------------------
// eged_pkg
// Shared constants, tables and stage types of the density evaluator.
// ----------------------------------------------------------------------------
package eged_pkg;

    localparam int OUT_FRAC_BITS = 24;
    localparam int DENS_W        = OUT_FRAC_BITS + 1;
    localparam logic [DENS_W-1:0] ONE_OUT = DENS_W'(1) << OUT_FRAC_BITS;

    localparam logic [1:0] RGN_CORE = 2'd0;
    localparam logic [1:0] RGN_LOW  = 2'd1;
    localparam logic [1:0] RGN_HIGH = 2'd2;

    localparam logic [1:0] CFG_CENTER = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_K_LOW  = 2'd2;
    localparam logic [1:0] CFG_K_HIGH = 2'd3;

    localparam logic [23:0] T_MAX_POS = 24'd8388607;
    localparam logic [23:0] T_MAX_NEG = 24'd8388608;

    // log2(e) and ln(2), both with 32 fractional bits.
    localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;

    localparam int SERIES_STEPS = 12;

    // floor(2^32 / n) for the series divisors.
    localparam logic [31:0] RECIP [2:13] = '{
        32'd2147483648, 32'd1431655765, 32'd1073741824, 32'd858993459,
        32'd715827882,  32'd613566756,  32'd536870912,  32'd477218588,
        32'd429496729,  32'd390451572,  32'd357913941,  32'd330382099
    };

    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [23:0] quo;
    } div_res_t;

    typedef struct packed {
        logic [1:0]  region;
        logic        zero;
        logic [6:0]  ipart;
        logic [31:0] y;
    } exp_in_t;

    typedef struct packed {
        logic [1:0]         region;
        logic               zero;
        logic [6:0]         ipart;
        logic [31:0]        y;
        logic [31:0]        term;
        logic signed [34:0] sum;
        logic [31:0]        v;
        logic [31:0]        q0;
    } ser_t;

endpackage

>>> src/exp_gauss_exp_density.sv
// ----------------------------------------------------------------------------
// exp_gauss_exp_density
// Unnormalized Gaussian-core density with exponential tails on both sides.
// ----------------------------------------------------------------------------
// The block takes one mass word per cycle, unless the output word is held,
// and returns one density and region word for each, through 25 stages of
// bit-serial division by width, 5 stages of region choice and exponent
// scaling, 37 stages of the 2^-f series (three per term) and the output
// register. The whole pipeline advances together and holds while the output
// word waits to be taken. Configuration may be written only while no word
// is in flight.
module exp_gauss_exp_density (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [31:0]            mass,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [eged_pkg::DENS_W-1:0]   density,
    output logic [1:0]                    region,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [31:0]                   cfg_data
);

    logic signed [31:0]  center_reg;
    logic [30:0]         width_reg;
    logic [23:0]         k_low_reg;
    logic [23:0]         k_high_reg;

    logic                en;
    logic                div_valid;
    eged_pkg::div_res_t  div_res;
    logic                tail_valid;
    eged_pkg::exp_in_t   tail_res;

    assign cfg_ready    = 1'b1;
    assign en           = !(result_valid && result_stall);
    assign sample_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= 32'sd0;
            width_reg  <= 31'd65536;
            k_low_reg  <= 24'd131072;
            k_high_reg <= 24'd131072;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                eged_pkg::CFG_CENTER: center_reg <= $signed(cfg_data);
                eged_pkg::CFG_WIDTH:  width_reg  <= cfg_data[30:0];
                eged_pkg::CFG_K_LOW:  k_low_reg  <= cfg_data[23:0];
                eged_pkg::CFG_K_HIGH: k_high_reg <= cfg_data[23:0];
                default:              center_reg <= center_reg;
            endcase
        end
    end

    eged_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample_valid),
        .mass      (mass),
        .center    (center_reg),
        .width     (width_reg),
        .out_valid (div_valid),
        .res       (div_res)
    );

    eged_tail u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .dres      (div_res),
        .k_low     (k_low_reg),
        .k_high    (k_high_reg),
        .out_valid (tail_valid),
        .res       (tail_res)
    );

    eged_exp2 u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tail_valid),
        .ein       (tail_res),
        .out_valid (result_valid),
        .density   (density),
        .region    (region)
    );

endmodule

>>> src/eged_div.sv
// ----------------------------------------------------------------------------
// eged_div
// Distance from center, rounded and divided by width, one quotient bit a stage.
// ----------------------------------------------------------------------------
module eged_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [31:0]      mass,
    input  logic signed [31:0]      center,
    input  logic [30:0]             width,
    output logic                    out_valid,
    output eged_pkg::div_res_t      res
);

    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [30:0]        wdiv;
    logic [48:0]        num;
    logic               ovf;

    logic               vld_reg [0:24];
    logic [48:0]        rem_reg [0:24];
    logic [23:0]        quo_reg [0:24];
    logic               neg_reg [0:24];
    logic               ovf_reg [0:24];

    logic [48:0]        rem_next [1:24];
    logic [23:0]        quo_next [1:24];

    always_comb
    begin
        diff = {mass[31], mass} - {center[31], center};
        mag  = diff[32] ? 33'(-diff) : 33'(diff);
        wdiv = (width == 31'd0) ? 31'd1 : width;
        num  = {mag, 16'd0} + 49'(wdiv >> 1);
        // A quotient of 2^24 or more saturates anyway.
        ovf  = {6'd0, num} >= {wdiv, 24'd0};
    end

    always_comb
    begin
        logic [54:0] dvs;
        dvs = '0;
        for (int k = 0; k < 24; k++)
        begin
            dvs = 55'(wdiv) << (23 - k);
            rem_next[k+1] = rem_reg[k];
            quo_next[k+1] = quo_reg[k];
            if ({6'd0, rem_reg[k]} >= dvs)
            begin
                rem_next[k+1]      = 49'({6'd0, rem_reg[k]} - dvs);
                quo_next[k+1][23-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= 24; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= 24; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            quo_reg[0] <= '0;
            neg_reg[0] <= diff[32];
            ovf_reg[0] <= ovf;
            for (int k = 1; k <= 24; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[24];
    assign res.neg   = neg_reg[24];
    assign res.ovf   = ovf_reg[24];
    assign res.quo   = quo_reg[24];

endmodule

>>> src/eged_tail.sv
// ----------------------------------------------------------------------------
// eged_tail
// Saturation, region choice, exponent product and base-2 scaling.
// ----------------------------------------------------------------------------
module eged_tail (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  eged_pkg::div_res_t   dres,
    input  logic [23:0]          k_low,
    input  logic [23:0]          k_high,
    output logic                 out_valid,
    output eged_pkg::exp_in_t    res
);

    logic [4:0]  vld_reg;

    logic [23:0] qs;
    logic [23:0] lim;
    logic [23:0] magt;
    logic [1:0]  rgn;
    logic [23:0] opa;
    logic [24:0] opb;

    logic [23:0] opa_reg;
    logic [24:0] opb_reg;
    logic [1:0]  rgn1_reg, rgn2_reg, rgn3_reg, rgn4_reg, rgn5_reg;
    logic [48:0] n_reg;
    logic        zero3_reg, zero4_reg, zero5_reg;
    logic [55:0] p1_reg;
    logic [48:0] p2_reg;
    logic [55:0] acc;
    logic [6:0]  ip4_reg, ip5_reg;
    logic [31:0] f4_reg;
    logic [63:0] yprod;
    logic [31:0] y5_reg;

    always_comb
    begin
        qs   = dres.ovf ? 24'hFFFFFF : dres.quo;
        lim  = dres.neg ? eged_pkg::T_MAX_NEG : eged_pkg::T_MAX_POS;
        magt = (qs > lim) ? lim : qs;
        if (dres.neg && (magt > k_low))
        begin
            rgn = eged_pkg::RGN_LOW;
            opa = k_low;
            opb = {magt, 1'b0} - {1'b0, k_low};
        end
        else if (!dres.neg && (magt > k_high))
        begin
            rgn = eged_pkg::RGN_HIGH;
            opa = k_high;
            opb = {magt, 1'b0} - {1'b0, k_high};
        end
        else
        begin
            rgn = eged_pkg::RGN_CORE;
            opa = magt;
            opb = {1'b0, magt};
        end
        acc   = p1_reg + 56'(p2_reg >> 16);
        yprod = {32'd0, f4_reg} * {32'd0, eged_pkg::LN2_Q32};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            opa_reg   <= opa;
            opb_reg   <= opb;
            rgn1_reg  <= rgn;

            n_reg     <= {25'd0, opa_reg} * {24'd0, opb_reg};
            rgn2_reg  <= rgn1_reg;

            // Exponents of 64 or more underflow to zero.
            zero3_reg <= |n_reg[48:39];
            p1_reg    <= {33'd0, n_reg[38:16]} * {23'd0, eged_pkg::LOG2E_Q32};
            p2_reg    <= {33'd0, n_reg[15:0]} * {16'd0, eged_pkg::LOG2E_Q32};
            rgn3_reg  <= rgn2_reg;

            ip4_reg   <= acc[55:49];
            f4_reg    <= acc[48:17];
            zero4_reg <= zero3_reg;
            rgn4_reg  <= rgn3_reg;

            y5_reg    <= yprod[63:32];
            ip5_reg   <= ip4_reg;
            zero5_reg <= zero4_reg;
            rgn5_reg  <= rgn4_reg;
        end
    end

    assign out_valid  = vld_reg[4];
    assign res.region = rgn5_reg;
    assign res.zero   = zero5_reg;
    assign res.ipart  = ip5_reg;
    assign res.y      = y5_reg;

endmodule

>>> src/eged_exp2.sv
// ----------------------------------------------------------------------------
// eged_exp2
// Series for 2^-f, one term over three stages, then the final scaling shift.
// ----------------------------------------------------------------------------
module eged_exp2 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  eged_pkg::exp_in_t             ein,
    output logic                          out_valid,
    output logic [eged_pkg::DENS_W-1:0]   density,
    output logic [1:0]                    region
);

    localparam int NSTG = 3 * eged_pkg::SERIES_STEPS + 1;

    logic                          vld_reg  [0:NSTG-1];
    eged_pkg::ser_t                stg_reg  [0:NSTG-1];
    eged_pkg::ser_t                stg_next [0:NSTG-1];

    logic                          out_vld_reg;
    logic [eged_pkg::DENS_W-1:0]   dens_reg;
    logic [1:0]                    rgn_reg;

    logic [32:0]                   p;
    logic [7:0]                    sh;
    logic [34:0]                   rnd;
    logic [eged_pkg::DENS_W-1:0]   dens_next;

    always_comb
    begin
        logic [63:0] pa [0:eged_pkg::SERIES_STEPS-1];
        logic [63:0] pb [0:eged_pkg::SERIES_STEPS-1];
        logic [35:0] chk [0:eged_pkg::SERIES_STEPS-1];
        logic [31:0] qc [0:eged_pkg::SERIES_STEPS-1];
        // First term is y itself.
        stg_next[0].region = ein.region;
        stg_next[0].zero   = ein.zero;
        stg_next[0].ipart  = ein.ipart;
        stg_next[0].y      = ein.y;
        stg_next[0].term   = ein.y;
        stg_next[0].sum    = 35'sh100000000 - $signed({3'd0, ein.y});
        stg_next[0].v      = '0;
        stg_next[0].q0     = '0;
        for (int j = 0; j < eged_pkg::SERIES_STEPS; j++)
        begin
            pa[j] = {32'd0, stg_reg[3*j].term} * {32'd0, stg_reg[3*j].y};
            stg_next[3*j+1]   = stg_reg[3*j];
            stg_next[3*j+1].v = pa[j][63:32];

            pb[j] = {32'd0, stg_reg[3*j+1].v} * {32'd0, eged_pkg::RECIP[j+2]};
            stg_next[3*j+2]    = stg_reg[3*j+1];
            stg_next[3*j+2].q0 = pb[j][63:32];

            // The reciprocal product is at most one below the true quotient.
            chk[j] = {4'd0, stg_reg[3*j+2].v} - ({4'd0, stg_reg[3*j+2].q0} * 36'(j + 2));
            qc[j]  = (chk[j] >= 36'(j + 2)) ? stg_reg[3*j+2].q0 + 32'd1 : stg_reg[3*j+2].q0;
            stg_next[3*j+3]      = stg_reg[3*j+2];
            stg_next[3*j+3].term = qc[j];
            if ((j & 1) == 1)
            begin
                stg_next[3*j+3].sum = stg_reg[3*j+2].sum - $signed({3'd0, qc[j]});
            end
            else
            begin
                stg_next[3*j+3].sum = stg_reg[3*j+2].sum + $signed({3'd0, qc[j]});
            end
        end
    end

    always_comb
    begin
        if (stg_reg[NSTG-1].sum < 0)
        begin
            p = '0;
        end
        else if (stg_reg[NSTG-1].sum > 35'sh100000000)
        begin
            p = 33'h100000000;
        end
        else
        begin
            p = stg_reg[NSTG-1].sum[32:0];
        end
        sh  = 8'(32 - eged_pkg::OUT_FRAC_BITS) + {1'b0, stg_reg[NSTG-1].ipart};
        rnd = '0;
        if (stg_reg[NSTG-1].zero || (sh >= 8'd34))
        begin
            dens_next = '0;
        end
        else if (sh == 8'd0)
        begin
            dens_next = p[eged_pkg::DENS_W-1:0];
        end
        else
        begin
            rnd = ({2'd0, p} + (35'd1 << (sh - 8'd1))) >> sh;
            dens_next = rnd[eged_pkg::DENS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < NSTG; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
            out_vld_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                stg_reg[s] <= stg_next[s];
            end
            dens_reg <= dens_next;
            rgn_reg  <= stg_reg[NSTG-1].region;
        end
    end

    assign out_valid = out_vld_reg;
    assign density   = dens_reg;
    assign region    = rgn_reg;

endmodule

>>> src/eged_check.sv
// ----------------------------------------------------------------------------
// eged_check
// Port-level checks of the density evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module eged_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_stall,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic [eged_pkg::DENS_W-1:0]   density,
    input  logic [1:0]                    region
);

    // A held result word stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(density) && $stable(region))
        else $error("result word changed while stalled");

    // The input side only stalls when the output word is held.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
        else $error("input stalled without output back-pressure");

    a_region: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (region == eged_pkg::RGN_CORE) || (region == eged_pkg::RGN_LOW)
                         || (region == eged_pkg::RGN_HIGH))
        else $error("bad region code");

    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> density <= eged_pkg::ONE_OUT)
        else $error("density above peak");

endmodule

bind exp_gauss_exp_density eged_check u_eged_check (.*);

>>> verif/tb_exp_gauss_exp_density.sv
// ----------------------------------------------------------------------------
// tb_exp_gauss_exp_density
// Self-checking testbench for the exponential-Gaussian-exponential density.
// A short directed table runs first under the reset settings. Random phases
// follow under several register settings, including the extremes. Each
// accepted mass word is scored by a bit-exact predictor or its table entry,
// and every result word is compared in order. Both sides stall at random,
// and once the receiver holds off long enough for the pipeline to fill up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_exp_gauss_exp_density;

    typedef struct packed {
        logic [eged_pkg::DENS_W-1:0] density;
        logic [1:0]                  region;
    } dens_word_t;

    typedef struct {
        logic signed [31:0] mass;
        logic               typed;
        dens_word_t         want;
    } dir_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          sample_valid;
    logic                          sample_stall;
    logic signed [31:0]            mass;
    logic                          result_valid;
    logic                          result_stall;
    logic [eged_pkg::DENS_W-1:0]   density;
    logic [1:0]                    region;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [1:0]                    cfg_index;
    logic [31:0]                   cfg_data;

    // Register copies used by the predictor.
    longint               cur_center;
    longint unsigned      cur_width;
    longint unsigned      cur_klow;
    longint unsigned      cur_khigh;

    dens_word_t           density_q[$];
    int                   err_cnt;
    int                   n_accepted;
    bit                   quiet;
    bit                   long_hold_done;

    exp_gauss_exp_density DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .mass         (mass),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .density      (density),
        .region       (region),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #3ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic dens_word_t predict_density(logic signed [31:0] m);
        longint          diff;
        longint          t;
        longint          kl;
        longint          kh;
        longint          nv;
        longint          sum;
        longint unsigned mag;
        longint unsigned w;
        longint unsigned q;
        longint unsigned acc;
        longint unsigned b;
        longint unsigned ip;
        longint unsigned y;
        longint unsigned term;
        longint unsigned p;
        longint unsigned s;
        dens_word_t      r;
        diff = longint'(m) - cur_center;
        mag  = (diff < 0) ? longint'(-diff) : diff;
        w    = (cur_width == 0) ? 1 : cur_width;
        q    = ((mag << 16) + (w >> 1)) / w;
        if (diff < 0)
        begin
            if (q > 8388608)
                q = 8388608;
            t = -longint'(q);
        end
        else
        begin
            if (q > 8388607)
                q = 8388607;
            t = q;
        end
        kl = cur_klow;
        kh = cur_khigh;
        if (t < -kl)
        begin
            r.region = eged_pkg::RGN_LOW;
            nv = -2 * kl * t - kl * kl;
        end
        else if (t > kh)
        begin
            r.region = eged_pkg::RGN_HIGH;
            nv = 2 * kh * t - kh * kh;
        end
        else
        begin
            r.region = eged_pkg::RGN_CORE;
            nv = t * t;
        end
        if (nv < 0)
            nv = 0;
        r.density = '0;
        if (nv < (longint'(1) << 39))
        begin
            acc  = (longint'(nv) >> 16) * 64'd6196328019
                 + (((nv & 64'hFFFF) * 64'd6196328019) >> 16);
            b    = acc >> 17;
            ip   = b >> 32;
            y    = ((b & 64'hFFFF_FFFF) * 64'd2977044472) >> 32;
            term = 64'd4294967296;
            sum  = 64'd4294967296;
            for (int n = 1; n <= 13; n++)
            begin
                term = ((term * y) >> 32) / n;
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > 64'sd4294967296)
                sum = 64'sd4294967296;
            p = sum;
            s = 32 + ip - eged_pkg::OUT_FRAC_BITS;
            if (s < 64)
            begin
                if (s != 0)
                    p = (p + (longint'(1) << (s - 1))) >> s;
                r.density = p[eged_pkg::DENS_W-1:0];
            end
        end
        return r;
    endfunction

    // Leaves the write strobe raised; the caller drops it after the last write.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            eged_pkg::CFG_CENTER: cur_center = longint'($signed(val));
            eged_pkg::CFG_WIDTH:  cur_width  = val[30:0];
            eged_pkg::CFG_K_LOW:  cur_klow   = val[23:0];
            eged_pkg::CFG_K_HIGH: cur_khigh  = val[23:0];
            default:              cur_center = cur_center;
        endcase
    endtask

    // Waits until the pipeline has drained before the registers change.
    task automatic load_settings(logic [31:0] c, logic [31:0] w, logic [31:0] kl,
                                 logic [31:0] kh);
        sample_valid <= 1'b0;
        while (density_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        write_reg(eged_pkg::CFG_CENTER, c);
        write_reg(eged_pkg::CFG_WIDTH, w);
        write_reg(eged_pkg::CFG_K_LOW, kl);
        write_reg(eged_pkg::CFG_K_HIGH, kh);
        cfg_valid <= 1'b0;
    endtask

    // Offers one mass word, holds it until taken, then maybe idles a while.
    task automatic send_mass(logic signed [31:0] m, bit typed, dens_word_t want);
        sample_valid <= 1'b1;
        mass         <= m;
        do
            @(posedge clk);
        while (sample_stall);
        density_q.push_back(typed ? want : predict_density(m));
        n_accepted++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] pick_mass();
        longint off;
        if ($urandom_range(0, 9) < 7)
        begin
            off = longint'($urandom_range(0, 1048576)) - 524288;
            return 32'(cur_center + (off * longint'(cur_width)) / 65536);
        end
        return $urandom;
    endfunction

    task automatic run_random(int count);
        dens_word_t none;
        none = '0;
        repeat (count) send_mass(pick_mass(), 1'b0, none);
    endtask

    // Receiver side: random stall bursts, plus one long hold-off.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && n_accepted >= 200)
            begin
                long_hold_done = 1'b1;
                result_stall <= 1'b1;
                repeat (300) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        dens_word_t exp_w;
        if (rst_n && result_valid && !result_stall)
        begin
            if (density_q.size() == 0)
            begin
                $error("result word with nothing expected: density %0d region %0d",
                       density, region);
                err_cnt++;
            end
            else
            begin
                exp_w = density_q.pop_front();
                if (density !== exp_w.density)
                begin
                    $error("density: expected %0d, actual %0d", exp_w.density, density);
                    err_cnt++;
                end
                if (region !== exp_w.region)
                begin
                    $error("region: expected %0d, actual %0d", exp_w.region, region);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t dir_rows[$];
        dens_word_t none;
        none = '0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        mass         = '0;
        cfg_valid    = 1'b0;
        cfg_index    = eged_pkg::CFG_CENTER;
        cfg_data     = '0;
        err_cnt      = 0;
        n_accepted   = 0;
        quiet        = 1'b0;
        long_hold_done = 1'b0;
        cur_center   = 0;
        cur_width    = 65536;
        cur_klow     = 131072;
        cur_khigh    = 131072;

        // Reset settings: center 0, width 1.0, both tails at two widths.
        dir_rows = '{
            '{32'sd0,              1'b1, '{eged_pkg::ONE_OUT, eged_pkg::RGN_CORE}},
            '{32'h8000_0000,       1'b1, '{'0, eged_pkg::RGN_LOW}},
            '{32'h7FFF_FFFF,       1'b1, '{'0, eged_pkg::RGN_HIGH}},
            '{-32'sd131072,        1'b0, '{'0, eged_pkg::RGN_CORE}},
            '{32'sd131072,         1'b0, '{'0, eged_pkg::RGN_CORE}},
            '{-32'sd131073,        1'b0, '{'0, eged_pkg::RGN_CORE}},
            '{32'sd131073,         1'b0, '{'0, eged_pkg::RGN_CORE}},
            '{32'sd65536,          1'b0, '{'0, eged_pkg::RGN_CORE}},
            '{-32'sd65536,         1'b0, '{'0, eged_pkg::RGN_CORE}},
            '{32'sd1,              1'b0, '{'0, eged_pkg::RGN_CORE}},
            '{-32'sd1,             1'b0, '{'0, eged_pkg::RGN_CORE}},
            '{32'sd1310720,        1'b0, '{'0, eged_pkg::RGN_CORE}},
            '{-32'sd2621440,       1'b0, '{'0, eged_pkg::RGN_CORE}},
            '{32'sd786432,         1'b0, '{'0, eged_pkg::RGN_CORE}},
            '{32'h5555_5555,       1'b0, '{'0, eged_pkg::RGN_CORE}},
            '{32'hAAAA_AAAA,       1'b0, '{'0, eged_pkg::RGN_CORE}}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_mass(dir_rows[i].mass, dir_rows[i].typed, dir_rows[i].want);
        run_random(300);

        // Narrowest width with both tails starting at the center, center at its lowest.
        load_settings(32'h8000_0000, 32'd1, 32'd0, 32'd0);
        send_mass(32'h8000_0000, 1'b0, none);
        send_mass(32'h8000_0001, 1'b0, none);
        run_random(120);

        // Widest width, tails as far out as they go, center at its highest.
        load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF);
        send_mass(32'h8000_0000, 1'b0, none);
        send_mass(32'h7FFF_FFFF, 1'b0, none);
        run_random(120);

        // A width word of zero in its low bits is taken as one LSB.
        load_settings(32'd0, 32'h8000_0000, 32'd65536, 32'd32768);
        run_random(80);

        // Odd widths, where the rounding of t never lands on a tie.
        load_settings(32'd0, 32'd3, 32'd98304, 32'd163840);
        send_mass(32'sd1, 1'b0, none);
        send_mass(-32'sd1, 1'b0, none);
        run_random(100);

        repeat (3)
        begin
            load_settings($urandom, $urandom_range(256, 33554432),
                          $urandom_range(0, 393216), $urandom_range(0, 393216));
            run_random(100);
        end

        // Final stretch with both sides running flat out.
        quiet = 1'b1;
        run_random(150);
        sample_valid <= 1'b0;

        while (density_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
